@@ design/ffra_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ffra_pkg;

  localparam int unsigned FrameW   = 32;
  localparam int unsigned ReqCntW  = 24;
  localparam int unsigned BufW     = 24;
  localparam int unsigned LatW     = 3;
  localparam int unsigned StrideW  = 16;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  localparam logic [1:0] REG_BUFFER_ELEMENTS = 2'd0;
  localparam logic [1:0] REG_FRAME_LATENCY   = 2'd1;
  localparam logic [1:0] REG_ELEMENT_SIZE    = 2'd2;

  localparam logic [BufW-1:0]    BUFFER_ELEMENTS_RST = 24'd65536;
  localparam logic [LatW-1:0]    FRAME_LATENCY_RST   = 3'd2;
  localparam logic [StrideW-1:0] ELEMENT_SIZE_RST    = 16'd16;

  typedef struct packed {
    logic [FrameW-1:0]  frame_number;
    logic [ReqCntW-1:0] request_count;
  } ffra_req_t;

  typedef struct packed {
    logic               granted;
    logic [BufW-1:0]    grant_offset;
    logic [StrideW-1:0] grant_stride;
    logic               ring_fault;
  } ffra_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAIL_RD,
    ST_TAIL_CHK,
    ST_HEAD_RD,
    ST_HEAD_CHK,
    ST_FIT,
    ST_COMMIT
  } ffra_state_e;

endpackage

`default_nettype wire

@@ design/ffra_stream_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ffra_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/frame_fenced_ring_allocator_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Frame-fenced ring allocator. One request is taken at a time: req ready is high only while
// the sequencer is idle, so the next request is accepted only after the current one has
// been committed. The steps are serialised by the single read port of the segment table:
// every reclaim step reads the tail entry and checks it in the following cycle, then the
// head entry is read and checked, then the fit test runs, and the commit waits until the
// output register is free. A finished response waits in an output register while the next
// request is accepted. Segment entries carry valid bits cleared by reset, so no clearing
// pass follows reset. Registers (APB, pready always high): 0x0 buffer_elements, 0x4
// frame_latency, 0x8 element_size.
module frame_fenced_ring_allocator_core #(
  parameter int unsigned SEGMENT_SLOTS = 8,
  parameter int unsigned COUNT_BITS    = 24
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ffra_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [ffra_pkg::CfgDataW-1:0] pwdata,
  output logic      [ffra_pkg::CfgDataW-1:0] prdata,
  output logic                            pready,
  ffra_stream_if.sink                     req_i,
  ffra_stream_if.source                   rsp_o
);
  import ffra_pkg::*;

  localparam int unsigned SlotW = $clog2(SEGMENT_SLOTS);
  localparam int unsigned CntW  = COUNT_BITS;
  localparam int unsigned WideW = ((CntW > BufW) ? CntW : BufW) + 2;
  localparam int unsigned SegW  = FrameW + CntW;

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    return (s == SlotW'(SEGMENT_SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  logic [BufW-1:0]    buf_q;
  logic [LatW-1:0]    lat_q;
  logic [StrideW-1:0] esz_q;
  logic               cfg_we;

  ffra_state_e state_q, state_d;

  logic [FrameW-1:0]  frame_q, frame_d;
  logic [ReqCntW-1:0] n_q, n_d;
  logic [SlotW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]    cur_q, cur_d, used_q, used_d, hcnt_q, hcnt_d;
  logic               fault_q, fault_d;
  logic               free_ok_q, free_ok_d, direct_ok_q, direct_ok_d;
  logic [WideW-1:0]   rem_q, rem_d;

  logic [SegW-1:0]          seg_mem [SEGMENT_SLOTS];
  logic [SEGMENT_SLOTS-1:0] seg_vld_q;
  logic [SegW-1:0]          rd_word_q;
  logic                     rd_vld_q;
  logic                     mem_re, mem_we, vld_clr;
  logic [SlotW-1:0]         rd_addr, wr_addr;
  logic [SegW-1:0]          wr_word;
  logic [FrameW-1:0]        rd_frame;
  logic [CntW-1:0]          rd_cnt;

  logic      rsp_vld_q, rsp_vld_d;
  ffra_rsp_t rsp_q, rsp_d;
  logic      out_free;

  logic             expire;
  logic [WideW-1:0] n_w, buf_w, cur_w, used_w, hcnt_w, wrap_sum;
  logic             wrap_ok;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= BUFFER_ELEMENTS_RST;
      lat_q <= FRAME_LATENCY_RST;
      esz_q <= ELEMENT_SIZE_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_BUFFER_ELEMENTS: buf_q <= pwdata[BufW-1:0];
        REG_FRAME_LATENCY:   lat_q <= pwdata[LatW-1:0];
        REG_ELEMENT_SIZE:    esz_q <= pwdata[StrideW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BUFFER_ELEMENTS: prdata = CfgDataW'(buf_q);
      REG_FRAME_LATENCY:   prdata = CfgDataW'(lat_q);
      REG_ELEMENT_SIZE:    prdata = CfgDataW'(esz_q);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem[wr_addr] <= wr_word;
    end
    if (mem_re) begin
      rd_word_q <= seg_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we) begin
        seg_vld_q[wr_addr] <= 1'b1;
      end
      if (vld_clr) begin
        seg_vld_q[tail_q] <= 1'b0;
      end
      if (mem_re) begin
        rd_vld_q <= seg_vld_q[rd_addr];
      end
    end
  end

  assign rd_frame = rd_vld_q ? rd_word_q[SegW-1:CntW] : '0;
  assign rd_cnt   = rd_vld_q ? rd_word_q[CntW-1:0] : '0;

  assign n_w      = WideW'(n_q);
  assign buf_w    = WideW'(buf_q);
  assign cur_w    = WideW'(cur_q);
  assign used_w   = WideW'(used_q);
  assign hcnt_w   = WideW'(hcnt_q);
  assign wrap_sum = used_w + rem_q;
  assign wrap_ok  = (wrap_sum <= buf_w) && ((buf_w - wrap_sum) >= n_w);
  assign expire   = {1'b0, frame_q} >= ({1'b0, rd_frame} + (FrameW + 1)'(lat_q));
  assign out_free = !rsp_vld_q || rsp_o.ready;

  assign req_i.ready = (state_q == ST_IDLE);
  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (req_i.valid) state_d = ST_TAIL_RD;
      ST_TAIL_RD:  state_d = (tail_q == head_q) ? ST_HEAD_RD : ST_TAIL_CHK;
      ST_TAIL_CHK: state_d = expire ? ST_TAIL_RD : ST_HEAD_RD;
      ST_HEAD_RD:  state_d = ST_HEAD_CHK;
      ST_HEAD_CHK: state_d = ST_FIT;
      ST_FIT:      state_d = ST_COMMIT;
      ST_COMMIT:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    frame_d     = frame_q;
    n_d         = n_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cur_d       = cur_q;
    used_d      = used_q;
    hcnt_d      = hcnt_q;
    fault_d     = fault_q;
    free_ok_d   = free_ok_q;
    direct_ok_d = direct_ok_q;
    rem_d       = rem_q;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    vld_clr     = 1'b0;
    rd_addr     = tail_q;
    wr_addr     = head_q;
    wr_word     = {frame_q, hcnt_q};
    rsp_vld_d   = rsp_vld_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          frame_d = req_i.data.frame_number;
          n_d     = req_i.data.request_count;
          fault_d = 1'b0;
        end
      end
      ST_TAIL_RD: begin
        mem_re  = (tail_q != head_q);
        rd_addr = tail_q;
      end
      ST_TAIL_CHK: begin
        if (expire) begin
          used_d  = (used_q >= rd_cnt) ? used_q - rd_cnt : '0;
          vld_clr = 1'b1;
          tail_d  = next_slot(tail_q);
        end
      end
      ST_HEAD_RD: begin
        mem_re  = 1'b1;
        rd_addr = head_q;
      end
      ST_HEAD_CHK: begin
        if (frame_q != rd_frame) begin
          head_d  = next_slot(head_q);
          mem_we  = 1'b1;
          wr_addr = next_slot(head_q);
          wr_word = {frame_q, {CntW{1'b0}}};
          hcnt_d  = '0;
          fault_d = (next_slot(head_q) == tail_q);
        end else begin
          hcnt_d = rd_cnt;
        end
      end
      ST_FIT: begin
        free_ok_d   = (used_w < buf_w) ? ((buf_w - used_w) >= n_w) : (n_w == '0);
        direct_ok_d = (cur_w + n_w) <= buf_w;
        rem_d       = (cur_w < buf_w) ? buf_w - cur_w : '0;
      end
      ST_COMMIT: begin
        if (out_free) begin
          rsp_vld_d = 1'b1;
          rsp_d     = '{granted: 1'b0, grant_offset: '0, grant_stride: '0,
                        ring_fault: fault_q};
          if (free_ok_q && direct_ok_q) begin
            rsp_d.granted      = 1'b1;
            rsp_d.grant_offset = BufW'(cur_w);
            rsp_d.grant_stride = esz_q;
            cur_d   = CntW'(cur_w + n_w);
            used_d  = CntW'(used_w + n_w);
            mem_we  = 1'b1;
            wr_word = {frame_q, CntW'(hcnt_w + n_w)};
          end else if (free_ok_q && wrap_ok) begin
            rsp_d.granted      = 1'b1;
            rsp_d.grant_stride = esz_q;
            cur_d   = CntW'(n_w);
            used_d  = CntW'(wrap_sum + n_w);
            mem_we  = 1'b1;
            wr_word = {frame_q, CntW'(hcnt_w + rem_q + n_w)};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= SlotW'(1);
      tail_q    <= '0;
      cur_q     <= '0;
      used_q    <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      cur_q     <= cur_d;
      used_q    <= used_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q     <= frame_d;
    n_q         <= n_d;
    hcnt_q      <= hcnt_d;
    fault_q     <= fault_d;
    free_ok_q   <= free_ok_d;
    direct_ok_q <= direct_ok_d;
    rem_q       <= rem_d;
    rsp_q       <= rsp_d;
  end

endmodule

`default_nettype wire

@@ design/ffra_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ffra_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                req_valid,
  input wire logic                req_ready,
  input wire logic                rsp_valid,
  input wire logic                rsp_ready,
  input wire ffra_pkg::ffra_rsp_t rsp_data
);
  import ffra_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while a beat is still in work");

  a_rsp_only_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("response beat appeared without a request in work");

  a_refusal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_data.granted) |->
      (rsp_data.grant_offset == '0 && rsp_data.grant_stride == '0))
    else $error("refused beat carries offset or stride");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
    else $error("stalled response beat changed");

endmodule

bind frame_fenced_ring_allocator_core ffra_checker u_ffra_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .req_valid (req_i.valid),
  .req_ready (req_i.ready),
  .rsp_valid (rsp_o.valid),
  .rsp_ready (rsp_o.ready),
  .rsp_data  (rsp_o.data)
);

`default_nettype wire
